/* hdl/bpa_pkg.sv */
// bpa_pkg: shared constants, command and status codes and the buddy unit result type
// for the buddy page allocator. No dependencies.
`default_nettype none

package bpa_pkg;

  // default geometry
  localparam int unsigned PAGES_DEF = 4096;
  localparam int unsigned TOP_DEF   = 10;

  // order field width, fixed by the command port
  localparam int unsigned OW = 4;

  // widest page address the buddy result carries
  localparam int unsigned BUD_AW = 20;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_ORDER   = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  // buddy address plus bound check
  typedef struct packed {
    logic              in_range;
    logic [BUD_AW-1:0] addr;
  } bud_t;

endpackage

`default_nettype wire

/* hdl/bpa_ram.sv */
// bpa_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module bpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hdl/bpa_buddy.sv */
// bpa_buddy: shared address unit, flips the order bit of a page to get the buddy or
// upper half and checks it against the page count. Depends on bpa_pkg.
`default_nettype none

module bpa_buddy #(
  parameter int unsigned PAGES = bpa_pkg::PAGES_DEF
) (
  input  wire logic [$clog2(PAGES)-1:0] page_i,
  input  wire logic [bpa_pkg::OW-1:0]   order_i,
  output bpa_pkg::bud_t                 bud_o
);

  localparam int unsigned PW = $clog2(PAGES);
  localparam int unsigned XW = (PW > 16) ? PW + 1 : 17;

  logic [XW-1:0] flip;

  // buddy is the page with the order bit toggled
  assign flip = XW'(page_i) ^ (XW'(1) << order_i);
  assign bud_o.in_range = (flip < XW'(PAGES));
  assign bud_o.addr     = bpa_pkg::BUD_AW'(flip[PW-1:0]);

endmodule

`default_nettype wire

/* hdl/buddy_page_allocator.sv */
// buddy_page_allocator: top level, sequencer, free list registers and page metadata RAMs.
// Depends on bpa_pkg, bpa_ram and bpa_buddy.
//
// Binary buddy allocator over PAGES pages with orders 0 to TOP_ORDER. A command is taken
// when start is high and busy is low; its single result appears for one cycle with done_o
// and must be captured then, the block cannot be held off. After reset the block runs a
// clearing pass (busy high) that writes the initial metadata of every page. A query, a
// rejected order or an unused command answers in the cycle after it is taken. An allocate
// searches the lists upward, pops a head and links one upper half per split level; a free
// checks the page, then fetches and merges free buddies level by level and links the
// merged block. The pace is set by the single buddy address unit and the one read and one
// write per cycle of each metadata RAM.
`default_nettype none

module buddy_page_allocator #(
  parameter int unsigned PAGES     = bpa_pkg::PAGES_DEF,
  parameter int unsigned TOP_ORDER = bpa_pkg::TOP_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command_i,
  input  wire logic [3:0]  block_order_i,
  input  wire logic [11:0] page_index_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [11:0]      page_index_out_o,
  output logic [12:0]      free_blocks_o
);

  localparam int unsigned PW   = $clog2(PAGES);
  localparam int unsigned LW   = PW + 1;
  localparam int unsigned OW   = bpa_pkg::OW;
  localparam int unsigned BLK  = 1 << TOP_ORDER;
  localparam int unsigned NB   = PAGES / BLK;
  localparam int unsigned HD0  = (NB > 0) ? 0 : PAGES;
  localparam int unsigned TL0  = (NB > 0) ? (NB - 1) * BLK : PAGES;
  localparam logic [LW-1:0] NONE = LW'(PAGES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SEARCH, S_UNLINK, S_LINK, S_PUSH, S_FCHECK, S_FBUDDY, S_FMERGE
  } state_e;

  state_e            state_q, state_d;
  bpa_pkg::cmd_e     cmd_q, cmd_d;
  logic [OW-1:0]     ord_q, ord_d;
  logic [OW-1:0]     cur_q, cur_d;
  logic [PW-1:0]     p_q, p_d;
  logic [PW-1:0]     b_q, b_d;
  logic [LW-1:0]     clr_q, clr_d;
  logic [LW-1:0]     head_q [TOP_ORDER+1];
  logic [LW-1:0]     head_d [TOP_ORDER+1];
  logic [LW-1:0]     tail_q [TOP_ORDER+1];
  logic [LW-1:0]     tail_d [TOP_ORDER+1];
  logic [LW-1:0]     cnt_q  [TOP_ORDER+1];
  logic [LW-1:0]     cnt_d  [TOP_ORDER+1];
  logic              done_q, done_d;
  logic [1:0]        status_q, status_d;
  logic [11:0]       pout_q, pout_d;
  logic [12:0]       fb_q, fb_d;

  // metadata RAM ports
  logic [PW-1:0]     rd_addr;
  logic              ord_we, alc_we, fh_we, nxt_we, prv_we;
  logic [PW-1:0]     ord_wa, alc_wa, fh_wa, nxt_wa, prv_wa;
  logic [OW-1:0]     ord_wd, ord_rd;
  logic              alc_wd, alc_rd, fh_wd, fh_rd;
  logic [LW-1:0]     nxt_wd, nxt_rd, prv_wd, prv_rd;

  bpa_pkg::bud_t     bud;
  logic [PW-1:0]     tgt;

  // shared buddy address unit
  bpa_buddy #(.PAGES(PAGES)) u_buddy (
    .page_i  (p_q),
    .order_i (cur_q),
    .bud_o   (bud)
  );

  // per page metadata
  bpa_ram #(.WIDTH(OW), .DEPTH(PAGES)) u_ord_ram (
    .clk_i, .we_i(ord_we), .waddr_i(ord_wa), .wdata_i(ord_wd), .raddr_i(rd_addr),
    .rdata_o(ord_rd)
  );
  bpa_ram #(.WIDTH(1), .DEPTH(PAGES)) u_alc_ram (
    .clk_i, .we_i(alc_we), .waddr_i(alc_wa), .wdata_i(alc_wd), .raddr_i(rd_addr),
    .rdata_o(alc_rd)
  );
  bpa_ram #(.WIDTH(1), .DEPTH(PAGES)) u_fh_ram (
    .clk_i, .we_i(fh_we), .waddr_i(fh_wa), .wdata_i(fh_wd), .raddr_i(rd_addr),
    .rdata_o(fh_rd)
  );
  bpa_ram #(.WIDTH(LW), .DEPTH(PAGES)) u_nxt_ram (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_wa), .wdata_i(nxt_wd), .raddr_i(rd_addr),
    .rdata_o(nxt_rd)
  );
  bpa_ram #(.WIDTH(LW), .DEPTH(PAGES)) u_prv_ram (
    .clk_i, .we_i(prv_we), .waddr_i(prv_wa), .wdata_i(prv_wd), .raddr_i(rd_addr),
    .rdata_o(prv_rd)
  );

  // node pushed by the link step: upper half on a split, merged block on a free
  assign tgt = (cmd_q == bpa_pkg::CMD_ALLOC) ? bud.addr[PW-1:0] : p_q;

  // shared read address
  always_comb begin
    case (state_q)
      S_IDLE:   rd_addr = PW'(page_index_i);
      S_SEARCH: rd_addr = head_q[cur_q][PW-1:0];
      S_FBUDDY: rd_addr = bud.addr[PW-1:0];
      default:  rd_addr = p_q;
    endcase
  end

  // sequencer next state and datapath
  always_comb begin
    int unsigned ca;
    logic        cst;
    state_d  = state_q;
    cmd_d    = cmd_q;
    ord_d    = ord_q;
    cur_d    = cur_q;
    p_d      = p_q;
    b_d      = b_q;
    clr_d    = clr_q;
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    status_d = status_q;
    pout_d   = pout_q;
    fb_d     = fb_q;
    ord_we = 1'b0; ord_wa = p_q; ord_wd = '0;
    alc_we = 1'b0; alc_wa = p_q; alc_wd = 1'b0;
    fh_we  = 1'b0; fh_wa  = p_q; fh_wd  = 1'b0;
    nxt_we = 1'b0; nxt_wa = p_q; nxt_wd = NONE;
    prv_we = 1'b0; prv_wa = p_q; prv_wd = NONE;
    ca  = int'(clr_q);
    cst = ((ca % BLK) == 0) && (ca + BLK <= PAGES);

    case (state_q)
      // write initial metadata one page a cycle
      S_CLEAR: begin
        ord_we = 1'b1; ord_wa = clr_q[PW-1:0]; ord_wd = cst ? OW'(TOP_ORDER) : '0;
        alc_we = 1'b1; alc_wa = clr_q[PW-1:0]; alc_wd = 1'b0;
        fh_we  = 1'b1; fh_wa  = clr_q[PW-1:0]; fh_wd  = cst;
        nxt_we = 1'b1; nxt_wa = clr_q[PW-1:0];
        nxt_wd = (cst && (ca + 2 * BLK <= PAGES)) ? LW'(ca + BLK) : NONE;
        prv_we = 1'b1; prv_wa = clr_q[PW-1:0];
        prv_wd = (cst && (ca >= BLK)) ? LW'(ca - BLK) : NONE;
        clr_d  = clr_q + LW'(1);
        if (clr_q == LW'(PAGES - 1)) begin
          state_d = S_IDLE;
        end
      end

      // command transfer
      S_IDLE: begin
        if (start) begin
          cmd_d = bpa_pkg::cmd_e'(command_i);
          ord_d = OW'(block_order_i);
          cur_d = OW'(block_order_i);
          p_d   = PW'(page_index_i);
          status_d = bpa_pkg::ST_OK;
          pout_d   = '0;
          fb_d     = '0;
          case (bpa_pkg::cmd_e'(command_i))
            bpa_pkg::CMD_ALLOC: begin
              if (block_order_i > 4'(TOP_ORDER)) begin
                done_d = 1'b1; status_d = bpa_pkg::ST_ORDER;
              end else begin
                state_d = S_SEARCH;
              end
            end
            bpa_pkg::CMD_FREE: begin
              if (32'(page_index_i) >= 32'(PAGES)) begin
                done_d = 1'b1; status_d = bpa_pkg::ST_IGNORED;
              end else begin
                state_d = S_FCHECK;
              end
            end
            bpa_pkg::CMD_QUERY: begin
              done_d = 1'b1;
              if (block_order_i > 4'(TOP_ORDER)) begin
                status_d = bpa_pkg::ST_ORDER;
              end else begin
                fb_d = 13'(cnt_q[block_order_i]);
              end
            end
            default: begin
              done_d = 1'b1; status_d = bpa_pkg::ST_IGNORED;
            end
          endcase
        end
      end

      // find smallest non-empty list at or above the order
      S_SEARCH: begin
        if (head_q[cur_q] != NONE) begin
          p_d     = head_q[cur_q][PW-1:0];
          state_d = S_UNLINK;
        end else if (cur_q == OW'(TOP_ORDER)) begin
          done_d   = 1'b1;
          status_d = bpa_pkg::ST_OOM;
          state_d  = S_IDLE;
        end else begin
          cur_d = cur_q + OW'(1);
        end
      end

      // pop the list head and mark it allocated
      S_UNLINK: begin
        head_d[cur_q] = nxt_rd;
        if (nxt_rd == NONE) begin
          tail_d[cur_q] = NONE;
        end else begin
          prv_we = 1'b1; prv_wa = nxt_rd[PW-1:0]; prv_wd = NONE;
        end
        if (cnt_q[cur_q] != '0) begin
          cnt_d[cur_q] = cnt_q[cur_q] - LW'(1);
        end
        fh_we  = 1'b1; fh_wd  = 1'b0;
        ord_we = 1'b1; ord_wd = ord_q;
        alc_we = 1'b1; alc_wd = 1'b1;
        if (cur_q > ord_q) begin
          cur_d   = cur_q - OW'(1);
          state_d = S_LINK;
        end else begin
          done_d  = 1'b1;
          pout_d  = 12'(p_q);
          state_d = S_IDLE;
        end
      end

      // hook the node behind the current tail
      S_LINK: begin
        b_d = tgt;
        if (tail_q[cur_q] != NONE) begin
          nxt_we = 1'b1; nxt_wa = tail_q[cur_q][PW-1:0]; nxt_wd = LW'(tgt);
        end
        state_d = S_PUSH;
      end

      // finish tail append
      S_PUSH: begin
        nxt_we = 1'b1; nxt_wa = b_q; nxt_wd = NONE;
        prv_we = 1'b1; prv_wa = b_q; prv_wd = tail_q[cur_q];
        alc_we = 1'b1; alc_wa = b_q; alc_wd = 1'b0;
        fh_we  = 1'b1; fh_wa  = b_q; fh_wd  = 1'b1;
        ord_we = 1'b1; ord_wa = b_q; ord_wd = cur_q;
        if (tail_q[cur_q] == NONE) begin
          head_d[cur_q] = LW'(b_q);
        end
        tail_d[cur_q] = LW'(b_q);
        cnt_d[cur_q]  = cnt_q[cur_q] + LW'(1);
        if ((cmd_q == bpa_pkg::CMD_ALLOC) && (cur_q > ord_q)) begin
          cur_d   = cur_q - OW'(1);
          state_d = S_LINK;
        end else begin
          done_d  = 1'b1;
          pout_d  = 12'(p_q);
          state_d = S_IDLE;
        end
      end

      // check the page being freed
      S_FCHECK: begin
        if (!alc_rd) begin
          done_d   = 1'b1;
          status_d = bpa_pkg::ST_IGNORED;
          state_d  = S_IDLE;
        end else begin
          alc_we  = 1'b1; alc_wd = 1'b0;
          cur_d   = ord_rd;
          state_d = S_FBUDDY;
        end
      end

      // fetch the buddy metadata
      S_FBUDDY: begin
        if ((cur_q >= OW'(TOP_ORDER)) || !bud.in_range) begin
          state_d = S_LINK;
        end else begin
          b_d     = bud.addr[PW-1:0];
          state_d = S_FMERGE;
        end
      end

      // merge with a free buddy of equal order
      S_FMERGE: begin
        if (alc_rd || !fh_rd || (ord_rd != cur_q)) begin
          state_d = S_LINK;
        end else begin
          if (prv_rd == NONE) begin
            head_d[cur_q] = nxt_rd;
          end else begin
            nxt_we = 1'b1; nxt_wa = prv_rd[PW-1:0]; nxt_wd = nxt_rd;
          end
          if (nxt_rd == NONE) begin
            tail_d[cur_q] = prv_rd;
          end else begin
            prv_we = 1'b1; prv_wa = nxt_rd[PW-1:0]; prv_wd = prv_rd;
          end
          if (cnt_q[cur_q] != '0) begin
            cnt_d[cur_q] = cnt_q[cur_q] - LW'(1);
          end
          fh_we   = 1'b1; fh_wa = b_q; fh_wd = 1'b0;
          p_d     = p_q & b_q;
          cur_d   = cur_q + OW'(1);
          state_d = S_FBUDDY;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state, list registers and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cmd_q    <= bpa_pkg::CMD_NONE;
      ord_q    <= '0;
      cur_q    <= '0;
      clr_q    <= '0;
      done_q   <= 1'b0;
      status_q <= bpa_pkg::ST_OK;
      pout_q   <= '0;
      fb_q     <= '0;
      for (int i = 0; i <= TOP_ORDER; i++) begin
        head_q[i] <= (i == TOP_ORDER) ? LW'(HD0) : NONE;
        tail_q[i] <= (i == TOP_ORDER) ? LW'(TL0) : NONE;
        cnt_q[i]  <= (i == TOP_ORDER) ? LW'(NB) : '0;
      end
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      ord_q    <= ord_d;
      cur_q    <= cur_d;
      clr_q    <= clr_d;
      done_q   <= done_d;
      status_q <= status_d;
      pout_q   <= pout_d;
      fb_q     <= fb_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
    end
  end

  // page registers carry no reset
  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    b_q <= b_d;
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign page_index_out_o = pout_q;
  assign free_blocks_o    = fb_q;

  // no result while the metadata is being cleared
  a_no_done_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !done_o)
    else $error("result strobe during clearing pass");

  // an accepted command either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted command was dropped");

  // head and tail of a list are empty together
  a_list_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != S_CLEAR) && (cur_q <= OW'(TOP_ORDER))) |->
      ((head_q[cur_q] == NONE) == (tail_q[cur_q] == NONE)))
    else $error("free list head and tail disagree");

  // a list count is zero exactly when the list is empty
  a_list_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != S_CLEAR) && (cur_q <= OW'(TOP_ORDER))) |->
      ((cnt_q[cur_q] == '0) == (head_q[cur_q] == NONE)))
    else $error("free list count out of step with list");

endmodule

`default_nettype wire

/* test/tb_checker.sv */
// tb_checker: watches command transfers and result strobes of the buddy page allocator,
// predicts each result with its own buddy model and counts mismatches. Depends on bpa_pkg.
`default_nettype none

module tb_checker #(
  parameter int unsigned NPG = 4096,
  parameter int unsigned TOPO = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  command_i,
  input  wire logic [3:0]  block_order_i,
  input  wire logic [11:0] page_index_i,
  input  wire logic        done_o,
  input  wire logic [1:0]  status_o,
  input  wire logic [11:0] page_index_out_o,
  input  wire logic [12:0] free_blocks_o,
  output int               err_cnt,
  output int               pending_cnt
);

  localparam int NIL = NPG;
  localparam int DUE_N = 8;

  typedef struct packed {
    bpa_pkg::status_e st;
    logic [11:0]      pg;
    logic [12:0]      cnt;
  } alloc_res_t;

  // page metadata mirror
  logic [3:0] pg_ord [NPG];
  bit         pg_used [NPG];
  bit         pg_head [NPG];
  int         nxt [NPG];
  int         prv [NPG];
  int         fl_head [TOPO+1];
  int         fl_tail [TOPO+1];
  int         fl_cnt [TOPO+1];

  // expected results in transfer order
  alloc_res_t due_buf [DUE_N];
  int         due_rd = 0;
  int         due_wr = 0;

  task automatic report(input string what, input int got, input int want);
    err_cnt++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  function automatic void list_append(int o, int p);
    nxt[p] = NIL;
    prv[p] = fl_tail[o];
    if (fl_tail[o] == NIL) fl_head[o] = p;
    else nxt[fl_tail[o]] = p;
    fl_tail[o] = p;
    fl_cnt[o]++;
    pg_head[p] = 1;
    pg_ord[p] = o[3:0];
  endfunction

  function automatic void list_remove(int o, int p);
    int n, v;
    n = nxt[p];
    v = prv[p];
    if (v == NIL) fl_head[o] = n;
    else nxt[v] = n;
    if (n == NIL) fl_tail[o] = v;
    else prv[n] = v;
    nxt[p] = NIL;
    prv[p] = NIL;
    if (fl_cnt[o] > 0) fl_cnt[o]--;
    pg_head[p] = 0;
  endfunction

  function automatic void heap_reset();
    for (int i = 0; i < NPG; i++) begin
      pg_ord[i] = 0; pg_used[i] = 0; pg_head[i] = 0; nxt[i] = NIL; prv[i] = NIL;
    end
    for (int i = 0; i <= TOPO; i++) begin
      fl_head[i] = NIL; fl_tail[i] = NIL; fl_cnt[i] = 0;
    end
    for (int i = 0; i + (1 << TOPO) <= NPG; i += (1 << TOPO)) list_append(TOPO, i);
  endfunction

  function automatic alloc_res_t heap_step(bpa_pkg::cmd_e c, int ord, int page);
    alloc_res_t r;
    int cur, p, o, b;
    r = '{st: bpa_pkg::ST_OK, pg: '0, cnt: '0};
    case (c)
      bpa_pkg::CMD_ALLOC: begin
        if (ord > TOPO) r.st = bpa_pkg::ST_ORDER;
        else begin
          cur = ord;
          while (cur <= TOPO && fl_head[cur] == NIL) cur++;
          if (cur > TOPO) r.st = bpa_pkg::ST_OOM;
          else begin
            p = fl_head[cur];
            list_remove(cur, p);
            // split down, upper halves go to the lower lists
            while (cur > ord) begin
              cur--;
              b = p + (1 << cur);
              pg_used[b] = 0;
              list_append(cur, b);
            end
            pg_ord[p] = ord[3:0];
            pg_used[p] = 1;
            pg_head[p] = 0;
            r.pg = p[11:0];
          end
        end
      end
      bpa_pkg::CMD_FREE: begin
        if (page >= NPG || !pg_used[page]) r.st = bpa_pkg::ST_IGNORED;
        else begin
          p = page;
          o = pg_ord[page];
          pg_used[page] = 0;
          // merge with free buddy heads of equal order
          while (o < TOPO) begin
            b = p ^ (1 << o);
            if (b >= NPG) break;
            if (pg_used[b] || !pg_head[b] || pg_ord[b] != o) break;
            list_remove(o, b);
            if (b < p) p = b;
            o++;
          end
          list_append(o, p);
          r.pg = p[11:0];
        end
      end
      bpa_pkg::CMD_QUERY: begin
        if (ord > TOPO) r.st = bpa_pkg::ST_ORDER;
        else r.cnt = fl_cnt[ord][12:0];
      end
      default: r.st = bpa_pkg::ST_IGNORED;
    endcase
    return r;
  endfunction

  assign pending_cnt = due_wr - due_rd;

  // predict on command transfer, compare on result strobe
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_res_t w;
    if (!rst_ni) begin
      heap_reset();
      due_rd = 0;
      due_wr = 0;
      err_cnt = 0;
    end else begin
      if (done_o) begin
        if (due_wr == due_rd) report("unexpected result", 1, 0);
        else begin
          w = due_buf[due_rd % DUE_N];
          due_rd++;
          if (status_o != w.st) report("status", status_o, w.st);
          if (page_index_out_o != w.pg) report("page_index_out", page_index_out_o, w.pg);
          if (free_blocks_o != w.cnt) report("free_blocks", free_blocks_o, w.cnt);
        end
      end
      if (start && !busy) begin
        due_buf[due_wr % DUE_N] =
          heap_step(bpa_pkg::cmd_e'(command_i), block_order_i, page_index_i);
        due_wr++;
      end
    end
  end

endmodule

`default_nettype wire

/* test/tb_top.sv */
// tb_top: stimulus and verdict for the buddy page allocator.
// Depends on bpa_pkg, buddy_page_allocator and tb_checker.
`default_nettype none

module tb_top;

  localparam int N_RAND = 1500;
  localparam int CYC_LIMIT = 600000;
  localparam int OWN_N = 4096;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic [1:0]  command_i = bpa_pkg::CMD_QUERY;
  logic [3:0]  block_order_i = '0;
  logic [11:0] page_index_i = '0;
  wire         busy, done_o;
  wire  [1:0]  status_o;
  wire  [11:0] page_index_out_o;
  wire  [12:0] free_blocks_o;
  int          err_cnt, pending_cnt;
  int          cyc = 0;
  int          n_alloc = 0, n_free = 0, n_query = 0;
  int          gap_left = 0;
  logic [11:0] owned [OWN_N];
  int          n_owned = 0;

  always #4 clk_i = ~clk_i;

  buddy_page_allocator dut (.*);

  tb_checker chk (.*);

  // watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // track result pages (page 0 apart) of successful allocates and frees to pick free targets
  always @(posedge clk_i)
    if (done_o && status_o == bpa_pkg::ST_OK && page_index_out_o != 0 && free_blocks_o == 0
        && n_owned < OWN_N) begin
      owned[n_owned] = page_index_out_o;
      n_owned++;
    end

  // one command transfer, optional idle gap before it
  task automatic issue(input bpa_pkg::cmd_e c, input logic [3:0] o, input logic [11:0] p,
                       input bit gaps);
    if (gaps && gap_left == 0 && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 17);
    while (gap_left > 0) begin
      start <= 0;
      @(posedge clk_i);
      gap_left--;
    end
    start <= 1;
    command_i <= c;
    block_order_i <= o;
    page_index_i <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    case (c)
      bpa_pkg::CMD_ALLOC: n_alloc++;
      bpa_pkg::CMD_FREE: n_free++;
      default: n_query++;
    endcase
  endtask

  task automatic drop_start();
    start <= 0;
    @(posedge clk_i);
  endtask

  function automatic logic [11:0] take_owned();
    int k;
    logic [11:0] v;
    k = $urandom_range(0, n_owned - 1);
    v = owned[k];
    owned[k] = owned[n_owned - 1];
    n_owned--;
    return v;
  endfunction

  initial begin
    int r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    // directed part
    issue(bpa_pkg::CMD_QUERY, 4'd10, 12'd0, 0);
    issue(bpa_pkg::CMD_QUERY, 4'd15, 12'd0, 0);
    issue(bpa_pkg::CMD_ALLOC, 4'd15, 12'd0, 0);
    issue(bpa_pkg::CMD_ALLOC, 4'd0, 12'd0, 0);
    issue(bpa_pkg::CMD_QUERY, 4'd0, 12'd0, 0);
    issue(bpa_pkg::CMD_QUERY, 4'd9, 12'd0, 0);
    issue(bpa_pkg::CMD_FREE, 4'd0, 12'd0, 0);
    issue(bpa_pkg::CMD_FREE, 4'd0, 12'd0, 0);
    issue(bpa_pkg::CMD_FREE, 4'd0, 12'hfff, 0);
    issue(bpa_pkg::CMD_NONE, 4'hf, 12'hfff, 0);
    repeat (5) issue(bpa_pkg::CMD_ALLOC, 4'd10, 12'd0, 0);
    issue(bpa_pkg::CMD_ALLOC, 4'd0, 12'd0, 0);
    issue(bpa_pkg::CMD_FREE, 4'd0, 12'd0, 0);
    issue(bpa_pkg::CMD_FREE, 4'd0, 12'd1024, 0);
    issue(bpa_pkg::CMD_FREE, 4'd0, 12'd2048, 0);
    issue(bpa_pkg::CMD_FREE, 4'd0, 12'd3072, 0);
    issue(bpa_pkg::CMD_QUERY, 4'd10, 12'd0, 0);
    issue(bpa_pkg::CMD_ALLOC, 4'd3, 12'd0, 0);
    issue(bpa_pkg::CMD_FREE, 4'd0, 12'd0, 0);
    // hold off until every result is back
    drop_start();
    while (pending_cnt != 0) @(posedge clk_i);
    // random part
    for (int i = 0; i < N_RAND; i++) begin
      bit gaps;
      gaps = (i < N_RAND - 200);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if ($urandom_range(0, 9) == 0)
          issue(bpa_pkg::CMD_ALLOC, 4'($urandom_range(0, 15)), 12'($urandom), gaps);
        else issue(bpa_pkg::CMD_ALLOC, 4'($urandom_range(0, 4)), 12'($urandom), gaps);
      end else if (r < 85 && n_owned != 0) begin
        issue(bpa_pkg::CMD_FREE, 4'($urandom), take_owned(), gaps);
      end else if (r < 90) begin
        issue(bpa_pkg::CMD_FREE, 4'($urandom), 12'($urandom), gaps);
      end else if (r < 98) begin
        issue(bpa_pkg::CMD_QUERY, 4'($urandom), 12'($urandom), gaps);
      end else begin
        issue(bpa_pkg::CMD_NONE, 4'($urandom), 12'($urandom), gaps);
      end
    end
    drop_start();
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d allocates, %0d frees, %0d queries or other commands",
             n_alloc, n_free, n_query);
    $display("with splits, merges, exhaustion, bad frees and oversize orders");
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
